// ===== sv/decq_pkg.sv =====
// Shared constants, codes and controller/datapath types for the byte deque.
`default_nettype none

package decq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned STS_W  = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

  // Result status codes
  localparam logic [STS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] ST_FULL  = 2'd2;

  // Ring offset from the front index
  typedef enum logic [2:0] {
    OFF_ZERO,    // front element
    OFF_BEFORE,  // slot ahead of the front (push front)
    OFF_TAIL,    // first free slot behind the back (push back)
    OFF_LAST,    // back element
    OFF_WALK     // dump walk position
  } off_sel_e;

  typedef struct packed {
    logic              latch;
    logic              mem_wr;
    logic              mem_rd;
    off_sel_e          off_sel;
    logic              front_inc;
    logic              front_dec;
    logic              count_inc;
    logic              count_dec;
    logic              walk_clr;
    logic              walk_inc;
    logic              out_load;
    logic [STS_W-1:0]  out_status;
    logic              out_use_rd;
    logic              out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             walk_last;
    logic             out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== sv/decq_in_if.sv =====
// Input channel: command and byte with valid/ready.
`default_nettype none

interface decq_in_if;
  logic                          valid;
  logic                          ready;
  logic [decq_pkg::CMD_W-1:0]    cmd;
  logic [decq_pkg::DATA_W-1:0]   data_in;

  modport source (output valid, output cmd, output data_in, input ready);
  modport sink   (input valid, input cmd, input data_in, output ready);
endinterface

`default_nettype wire

// ===== sv/decq_out_if.sv =====
// Output channel: status, byte and last flag with valid/ready.
`default_nettype none

interface decq_out_if;
  logic                          valid;
  logic                          ready;
  logic [decq_pkg::STS_W-1:0]    status;
  logic [decq_pkg::DATA_W-1:0]   data_out;
  logic                          last;

  modport source (output valid, output status, output data_out, output last, input ready);
  modport sink   (input valid, input status, input data_out, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/decq_ctrl.sv =====
// Controller state machine sequencing push, pop and dump.
`default_nettype none

module decq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  decq_pkg::dp_sts_t sts_i,
  output decq_pkg::dp_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_DUMP = 2'd3;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.off_sel = decq_pkg::OFF_ZERO;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end

      S_EXEC: begin
        case (sts_i.cmd) inside
          decq_pkg::CMD_PUSH_FRONT, decq_pkg::CMD_PUSH_BACK: begin
            if (sts_i.out_free) begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_last = 1'b1;
              if (sts_i.full) begin
                cmd_o.out_status = decq_pkg::ST_FULL;
              end else begin
                cmd_o.out_status = decq_pkg::ST_OK;
                cmd_o.mem_wr     = 1'b1;
                cmd_o.count_inc  = 1'b1;
                if (sts_i.cmd == decq_pkg::CMD_PUSH_FRONT) begin
                  cmd_o.off_sel   = decq_pkg::OFF_BEFORE;
                  cmd_o.front_dec = 1'b1;
                end else begin
                  cmd_o.off_sel = decq_pkg::OFF_TAIL;
                end
              end
              state_d = S_IDLE;
            end
          end

          decq_pkg::CMD_POP_FRONT, decq_pkg::CMD_POP_BACK: begin
            if (sts_i.empty) begin
              if (sts_i.out_free) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = decq_pkg::ST_EMPTY;
                cmd_o.out_last   = 1'b1;
                state_d          = S_IDLE;
              end
            end else begin
              cmd_o.mem_rd    = 1'b1;
              cmd_o.count_dec = 1'b1;
              if (sts_i.cmd == decq_pkg::CMD_POP_FRONT) begin
                cmd_o.off_sel   = decq_pkg::OFF_ZERO;
                cmd_o.front_inc = 1'b1;
              end else begin
                cmd_o.off_sel = decq_pkg::OFF_LAST;
              end
              state_d = S_POP;
            end
          end

          decq_pkg::CMD_DUMP: begin
            if (sts_i.empty) begin
              if (sts_i.out_free) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = decq_pkg::ST_EMPTY;
                cmd_o.out_last   = 1'b1;
                state_d          = S_IDLE;
              end
            end else begin
              cmd_o.mem_rd   = 1'b1;
              cmd_o.off_sel  = decq_pkg::OFF_ZERO;
              cmd_o.walk_clr = 1'b1;
              state_d        = S_DUMP;
            end
          end

          default: begin
            // unused code: dropped without a result
            state_d = S_IDLE;
          end
        endcase
      end

      S_POP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = decq_pkg::ST_OK;
          cmd_o.out_use_rd = 1'b1;
          cmd_o.out_last   = 1'b1;
          state_d          = S_IDLE;
        end
      end

      S_DUMP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = decq_pkg::ST_OK;
          cmd_o.out_use_rd = 1'b1;
          cmd_o.out_last   = sts_i.walk_last;
          if (sts_i.walk_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.mem_rd   = 1'b1;
            cmd_o.off_sel  = decq_pkg::OFF_WALK;
            cmd_o.walk_inc = 1'b1;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/decq_dp.sv =====
// Datapath: ring store, front index, count, walk counter and output register.
`default_nettype none

module decq_dp #(
  parameter int unsigned DEPTH = decq_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  decq_pkg::dp_cmd_t            cmd_i,
  output decq_pkg::dp_sts_t            sts_o,
  input  logic [decq_pkg::CMD_W-1:0]   in_cmd_i,
  input  logic [decq_pkg::DATA_W-1:0]  in_data_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [decq_pkg::STS_W-1:0]   out_status_o,
  output logic [decq_pkg::DATA_W-1:0]  out_data_o,
  output logic                         out_last_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [decq_pkg::CMD_W-1:0]  cmd_q;
  logic [decq_pkg::DATA_W-1:0] byte_q;
  logic [AW-1:0]               front_q;
  logic [CW-1:0]               count_q;
  logic [CW-1:0]               walk_q;
  logic [decq_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [decq_pkg::DATA_W-1:0] rd_data_q;
  logic                        out_valid_q;
  logic [decq_pkg::STS_W-1:0]  out_status_q;
  logic [decq_pkg::DATA_W-1:0] out_data_q;
  logic                        out_last_q;

  logic [CW-1:0] count_m1;
  logic [AW-1:0] offset;
  logic [AW:0]   sum;
  logic [AW-1:0] addr;
  logic [AW-1:0] front_d;

  assign count_m1 = count_q - CW'(1);

  always_comb begin
    unique case (cmd_i.off_sel)
      decq_pkg::OFF_ZERO:   offset = '0;
      decq_pkg::OFF_BEFORE: offset = AW'(DEPTH - 1);
      decq_pkg::OFF_TAIL:   offset = count_q[AW-1:0];
      decq_pkg::OFF_LAST:   offset = count_m1[AW-1:0];
      decq_pkg::OFF_WALK:   offset = walk_q[AW-1:0];
      default:              offset = '0;
    endcase
  end

  // front + offset modulo DEPTH; both terms below DEPTH
  assign sum  = {1'b0, front_q} + {1'b0, offset};
  assign addr = (sum >= (AW+1)'(DEPTH)) ? AW'(sum - (AW+1)'(DEPTH)) : sum[AW-1:0];

  always_comb begin
    front_d = front_q;
    if (cmd_i.front_dec) begin
      front_d = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
    end else if (cmd_i.front_inc) begin
      front_d = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      front_q <= front_d;
      if (cmd_i.count_inc) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.count_dec) begin
        count_q <= count_m1;
      end
      if (cmd_i.walk_clr) begin
        walk_q <= CW'(1);
      end else if (cmd_i.walk_inc) begin
        walk_q <= walk_q + CW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q  <= in_cmd_i;
      byte_q <= in_data_i;
    end
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_data_q   <= cmd_i.out_use_rd ? rd_data_q : '0;
      out_last_q   <= cmd_i.out_last;
    end
  end

  // ring store, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem_q[addr] <= byte_q;
    end
    if (cmd_i.mem_rd) begin
      rd_data_q <= mem_q[addr];
    end
  end

  assign sts_o.cmd       = cmd_q;
  assign sts_o.full      = (count_q == CW'(DEPTH));
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.walk_last = (walk_q == count_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_data_o   = out_data_q;
  assign out_last_o   = out_last_q;

endmodule

`default_nettype wire

// ===== sv/double_ended_char_queue_top.sv =====
// Top level of the double-ended byte queue held in a ring store.
// Push: the item is written, or refused when full, as its result beat is loaded.
//   Pop: accept, a registered memory read, then the result beat. Dump reads each element
//   in turn through that read. One item is taken at a time, until its final beat is loaded;
//   the dump walks one element a cycle via the single read port unless the output stalls.
// Reset: asynchronous, active low; empties the queue and front index, drops any
//   pending output beat. Store contents are not cleared and need no sweep.
`default_nettype none

module double_ended_char_queue_top #(
  parameter int unsigned DEPTH = decq_pkg::DEPTH_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  decq_in_if.sink    in_i,
  decq_out_if.source out_o
);

  // command and status between controller and datapath
  decq_pkg::dp_cmd_t dp_cmd;
  decq_pkg::dp_sts_t dp_sts;

  // Controller: takes one input beat at a time, then sequences the
  // memory access and result beats for that item.
  decq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  // Datapath: ring store, pointers, and the output register that lets
  // a finished result wait while the next beat is taken in.
  decq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .sts_o        (dp_sts),
    .in_cmd_i     (in_i.cmd),
    .in_data_i    (in_i.data_in),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_status_o (out_o.status),
    .out_data_o   (out_o.data_out),
    .out_last_o   (out_o.last)
  );

endmodule

`default_nettype wire
